// File: hw/rtl/session_reorder_buffer_unit_macros.svh
// assertion macros for the reorder buffer checker
`ifndef SESSION_REORDER_BUFFER_UNIT_MACROS_SVH
`define SESSION_REORDER_BUFFER_UNIT_MACROS_SVH
`define SRB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("srb check failed");
`define SRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("srb check failed");
`endif

// File: hw/rtl/srb_pkg.sv
// shared types and constants of the session reorder buffer
package srb_pkg;
  localparam int unsigned TableSlots = 16;
  localparam int unsigned HandleBits = 8;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_FETCH   = 2'd1,
    CMD_DONE    = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    K_STORED    = 3'd0,
    K_REJECTED  = 3'd1,
    K_RELEASED  = 3'd2,
    K_DELIVERED = 3'd3,
    K_NOTHING   = 3'd4,
    K_BUSY      = 3'd5,
    K_DONE      = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHECK,
    S_INS_CLEAR,
    S_INS_SCAN,
    S_INS_DECIDE,
    S_INS_STORE,
    S_FETCH_SCAN,
    S_FETCH_DECIDE,
    S_CLR,
    S_FINAL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic   latch;      // capture request fields
    logic   scan_start; // reset scan pointer and search results
    logic   scan_step;  // examine one slot
    logic   clear_step; // release current slot if valid
    logic   new_session;
    logic   ins_write;  // store request in chosen slot
    logic   fetch_take; // invalidate best slot
    logic   fetch_begin;
    logic   fetch_end;  // nothing delivered
    logic   done_apply;
    logic   timeout_apply;
    logic   emit;
    kind_e  emit_kind;
    logic   emit_slot;  // handle comes from a slot
    logic   emit_req;   // handle comes from request
    logic   emit_need;
    logic   emit_last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic scan_done;
    logic cur_valid;   // slot under clear pointer valid
    logic prev_reject;
    logic new_session;
    logic hit;
    logic free_found;
    logic dup_reject;
    logic best_found;
    logic best_late;   // seq below expected
    logic best_exp;    // seq equal expected
    logic best_stale;
    logic outstanding;
    logic timeout_ok;
    logic upd;
    logic clr;
  } sts_t;
endpackage

// File: hw/rtl/srb_datapath.sv
// slot table, session state and scan logic of the reorder buffer
module srb_datapath #(
  parameter int unsigned TABLE_SLOTS = srb_pkg::TableSlots,
  parameter int unsigned HANDLE_BITS = srb_pkg::HandleBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srb_pkg::ctl_t   ctl_i,
  output srb_pkg::sts_t   sts_o,
  input  logic [1:0]      command_i,
  input  logic [31:0]     session_id_i,
  input  logic [31:0]     sequence_id_i,
  input  logic [63:0]     packet_id_i,
  input  logic [7:0]      message_handle_i,
  input  logic            update_status_i,
  input  logic            clear_table_i,
  output logic            strobe_o,
  output logic [2:0]      kind_o,
  output logic [7:0]      handle_o,
  output logic            needs_processing_o,
  output logic            last_o
);
  import srb_pkg::*;
  localparam int unsigned IdxW = $clog2(TABLE_SLOTS);
  localparam int unsigned CntW = $clog2(TABLE_SLOTS + 1);

  logic [TABLE_SLOTS-1:0] valid_q, valid_d;
  logic [31:0]            seq_q [TABLE_SLOTS];
  logic [63:0]            pkt_q [TABLE_SLOTS];
  logic [HANDLE_BITS-1:0] hdl_q [TABLE_SLOTS];

  logic [1:0]  cmd_q;
  logic [31:0] ses_q, rseq_q, cur_ses_q, prev_ses_q, exp_q;
  logic [63:0] rpkt_q, fin_q;
  logic [HANDLE_BITS-1:0] rhdl_q;
  logic        upd_q, clr_q;
  logic        outst_q, pend_q, armed_q;

  logic [CntW-1:0] ptr_q;
  logic [IdxW-1:0] idx;
  logic        hit_q, free_q, best_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q, best_idx_q;

  logic        strobe_q, need_q, last_q;
  logic [2:0]  kind_q;
  logic [7:0]  hdl_out_q;

  logic [63:0] gap, revise;
  logic [IdxW-1:0] tgt_idx;

  assign idx = ptr_q[IdxW-1:0];
  assign tgt_idx = hit_q ? hit_idx_q : free_idx_q;
  assign gap = {32'd0, exp_q - 32'd1 - seq_q[best_idx_q]};
  assign revise = fin_q - gap;

  always_comb begin
    sts_o = '0;
    sts_o.cmd         = cmd_e'(cmd_q);
    sts_o.scan_done   = (ptr_q == CntW'(TABLE_SLOTS));
    sts_o.cur_valid   = !sts_o.scan_done && valid_q[idx];
    sts_o.prev_reject = (prev_ses_q != 32'd0) && (ses_q == prev_ses_q);
    sts_o.new_session = (ses_q != cur_ses_q);
    sts_o.hit         = hit_q;
    sts_o.free_found  = free_q;
    sts_o.dup_reject  = (rpkt_q != 64'd0) && (rpkt_q < pkt_q[hit_idx_q]);
    sts_o.best_found  = best_q;
    sts_o.best_late   = seq_q[best_idx_q] < exp_q;
    sts_o.best_exp    = seq_q[best_idx_q] == exp_q;
    sts_o.best_stale  = sts_o.best_late ? (pkt_q[best_idx_q] < revise)
                                        : (pkt_q[best_idx_q] < fin_q);
    sts_o.outstanding = outst_q;
    sts_o.timeout_ok  = !pend_q && !outst_q && armed_q;
    sts_o.upd         = upd_q;
    sts_o.clr         = clr_q;
  end

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.clear_step && sts_o.cur_valid) valid_d[idx] = 1'b0;
    if (ctl_i.ins_write) valid_d[tgt_idx] = 1'b1;
    if (ctl_i.fetch_take) valid_d[best_idx_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      cur_ses_q  <= '0;
      prev_ses_q <= '0;
      exp_q      <= 32'd1;
      fin_q      <= '0;
      outst_q    <= 1'b0;
      pend_q     <= 1'b0;
      armed_q    <= 1'b0;
      ptr_q      <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      best_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      best_idx_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      strobe_q <= ctl_i.emit;
      if (ctl_i.latch && command_i == CMD_INSERT) pend_q <= 1'b1;
      if (ctl_i.new_session) begin
        prev_ses_q <= cur_ses_q;
        cur_ses_q  <= ses_q;
        fin_q      <= '0;
        exp_q      <= 32'd1;
      end
      if (ctl_i.fetch_begin) begin
        outst_q <= 1'b1;
        armed_q <= 1'b1;
        pend_q  <= 1'b0;
      end
      if (ctl_i.fetch_end) begin
        outst_q <= 1'b0;
        armed_q <= 1'b0;
      end
      if (ctl_i.done_apply) begin
        outst_q <= 1'b0;
        if (upd_q) begin
          fin_q <= rpkt_q;
          exp_q <= clr_q ? 32'd1 : exp_q + 32'd1;
        end
      end
      if (ctl_i.timeout_apply) armed_q <= 1'b0;
      if (ctl_i.scan_start) begin
        ptr_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        best_q <= 1'b0;
      end else if ((ctl_i.scan_step || ctl_i.clear_step) && !sts_o.scan_done) begin
        ptr_q <= ptr_q + CntW'(1);
        if (ctl_i.scan_step) begin
          if (valid_q[idx] && seq_q[idx] == rseq_q && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx;
          end
          if (!valid_q[idx] && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= idx;
          end
          if (valid_q[idx] && (!best_q || seq_q[idx] < seq_q[best_idx_q])) begin
            best_q     <= 1'b1;
            best_idx_q <= idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q  <= command_i;
      ses_q  <= session_id_i;
      rseq_q <= sequence_id_i;
      rpkt_q <= packet_id_i;
      rhdl_q <= HANDLE_BITS'(message_handle_i);
      upd_q  <= update_status_i;
      clr_q  <= clear_table_i;
    end
    if (ctl_i.ins_write) begin
      seq_q[tgt_idx] <= rseq_q;
      pkt_q[tgt_idx] <= rpkt_q;
      hdl_q[tgt_idx] <= rhdl_q;
    end
    if (ctl_i.emit) begin
      kind_q <= ctl_i.emit_kind;
      need_q <= ctl_i.emit_need;
      last_q <= ctl_i.emit_last;
      if (ctl_i.clear_step)
        hdl_out_q <= 8'(hdl_q[idx]);
      else if (ctl_i.emit_slot)
        hdl_out_q <= 8'(ctl_i.fetch_take ? hdl_q[best_idx_q] : hdl_q[hit_idx_q]);
      else if (ctl_i.emit_req)
        hdl_out_q <= 8'(rhdl_q);
      else
        hdl_out_q <= '0;
    end
  end

  assign strobe_o = strobe_q;
  assign kind_o = kind_q;
  assign handle_o = hdl_out_q;
  assign needs_processing_o = need_q;
  assign last_o = last_q;
endmodule

// File: hw/rtl/srb_controller.sv
// command sequencer of the reorder buffer
module srb_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  srb_pkg::sts_t sts_i,
  output srb_pkg::ctl_t ctl_o
);
  import srb_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_INS_CHECK;
      S_INS_CHECK: begin
        unique case (sts_i.cmd)
          CMD_INSERT: begin
            if (sts_i.prev_reject) state_d = S_IDLE;
            else if (sts_i.new_session) state_d = S_INS_CLEAR;
            else state_d = S_INS_SCAN;
          end
          CMD_FETCH: state_d = sts_i.outstanding ? S_IDLE : S_FETCH_SCAN;
          CMD_DONE: state_d = (sts_i.upd && sts_i.clr) ? S_CLR : S_IDLE;
          default: state_d = sts_i.timeout_ok ? S_CLR : S_IDLE;
        endcase
      end
      S_INS_CLEAR: if (sts_i.scan_done) state_d = S_INS_SCAN;
      S_INS_SCAN: if (sts_i.scan_done) state_d = S_INS_DECIDE;
      S_INS_DECIDE: begin
        if (sts_i.hit && !sts_i.dup_reject) state_d = S_INS_STORE;
        else state_d = S_IDLE;
      end
      S_INS_STORE: state_d = S_IDLE;
      S_FETCH_SCAN: if (sts_i.scan_done) state_d = S_FETCH_DECIDE;
      S_FETCH_DECIDE: begin
        if (!sts_i.best_found || !(sts_i.best_late || sts_i.best_exp)) state_d = S_IDLE;
        else if (sts_i.best_stale) state_d = S_FETCH_SCAN;
        else state_d = S_IDLE;
      end
      S_CLR: if (sts_i.scan_done) state_d = S_FINAL;
      S_FINAL: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    ctl_o.emit_kind = K_DONE;
    busy_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        ctl_o.latch = start_i;
        ctl_o.scan_start = 1'b1;
      end
      S_INS_CHECK: begin
        ctl_o.scan_start = 1'b1;
        unique case (sts_i.cmd)
          CMD_INSERT: begin
            if (sts_i.prev_reject) begin
              ctl_o.emit = 1'b1;
              ctl_o.emit_kind = K_REJECTED;
              ctl_o.emit_req = 1'b1;
              ctl_o.emit_last = 1'b1;
            end
          end
          CMD_FETCH: begin
            if (sts_i.outstanding) begin
              ctl_o.emit = 1'b1;
              ctl_o.emit_kind = K_BUSY;
              ctl_o.emit_last = 1'b1;
            end else begin
              ctl_o.fetch_begin = 1'b1;
            end
          end
          CMD_DONE: begin
            ctl_o.done_apply = 1'b1;
            if (!(sts_i.upd && sts_i.clr)) begin
              ctl_o.emit = 1'b1;
              ctl_o.emit_last = 1'b1;
            end
          end
          default: begin
            if (sts_i.timeout_ok) ctl_o.timeout_apply = 1'b1;
            else begin
              ctl_o.emit = 1'b1;
              ctl_o.emit_last = 1'b1;
            end
          end
        endcase
      end
      S_INS_CLEAR: begin
        ctl_o.clear_step = 1'b1;
        ctl_o.emit = sts_i.cur_valid;
        ctl_o.emit_kind = K_RELEASED;
        if (sts_i.scan_done) begin
          ctl_o.new_session = 1'b1;
          ctl_o.scan_start = 1'b1;
        end
      end
      S_INS_SCAN: ctl_o.scan_step = 1'b1;
      S_INS_DECIDE: begin
        ctl_o.emit = 1'b1;
        ctl_o.emit_req = 1'b1;
        ctl_o.emit_last = 1'b1;
        if (sts_i.hit && sts_i.dup_reject) ctl_o.emit_kind = K_REJECTED;
        else if (!sts_i.hit && !sts_i.free_found) ctl_o.emit_kind = K_REJECTED;
        else begin
          ctl_o.ins_write = 1'b1;
          // a replaced duplicate releases its old handle first
          if (sts_i.hit) begin
            ctl_o.emit_kind = K_RELEASED;
            ctl_o.emit_req = 1'b0;
            ctl_o.emit_slot = 1'b1;
            ctl_o.emit_last = 1'b0;
          end else begin
            ctl_o.emit_kind = K_STORED;
          end
        end
      end
      S_INS_STORE: begin
        ctl_o.emit = 1'b1;
        ctl_o.emit_kind = K_STORED;
        ctl_o.emit_req = 1'b1;
        ctl_o.emit_last = 1'b1;
      end
      S_FETCH_SCAN: ctl_o.scan_step = 1'b1;
      S_FETCH_DECIDE: begin
        ctl_o.scan_start = 1'b1;
        ctl_o.emit = 1'b1;
        if (!sts_i.best_found || !(sts_i.best_late || sts_i.best_exp)) begin
          ctl_o.emit_kind = K_NOTHING;
          ctl_o.emit_last = 1'b1;
          ctl_o.fetch_end = 1'b1;
        end else begin
          ctl_o.fetch_take = 1'b1;
          ctl_o.emit_slot = 1'b1;
          if (sts_i.best_stale) ctl_o.emit_kind = K_RELEASED;
          else begin
            ctl_o.emit_kind = K_DELIVERED;
            ctl_o.emit_need = sts_i.best_exp;
            ctl_o.emit_last = 1'b1;
          end
        end
      end
      S_CLR: begin
        ctl_o.clear_step = 1'b1;
        ctl_o.emit = sts_i.cur_valid;
        ctl_o.emit_kind = K_RELEASED;
      end
      S_FINAL: begin
        ctl_o.emit = 1'b1;
        ctl_o.emit_last = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// File: hw/rtl/session_reorder_buffer_unit.sv
// insert: answered from the check state when rejected for its session, else after one table scan,
// plus a store step for a replaced duplicate and a clearing pass when a new session begins
// fetch: answered from the check state when busy, else one scan per released entry plus one
// complete and timeout: answered from the check state, or after a clearing pass when the table is cleared
// one command at a time, the next accepted at the edge that takes the final result; no stalls
// reset clears all valid bits and session state; busy low after reset
module session_reorder_buffer_unit #(
  parameter int unsigned TABLE_SLOTS = srb_pkg::TableSlots,
  parameter int unsigned HANDLE_BITS = srb_pkg::HandleBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] session_id_i,
  input  logic [31:0] sequence_id_i,
  input  logic [63:0] packet_id_i,
  input  logic [7:0]  message_handle_i,
  input  logic        update_status_i,
  input  logic        clear_table_i,
  output logic        strobe,
  output logic [2:0]  kind_o,
  output logic [7:0]  handle_o,
  output logic        needs_processing_o,
  output logic        last_o
);
  import srb_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic ctl_busy;

  srb_controller u_ctl (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start), .busy_o (ctl_busy),
    .sts_i (sts), .ctl_o (ctl)
  );

  srb_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ctl), .sts_o (sts),
    .command_i (command_i), .session_id_i (session_id_i),
    .sequence_id_i (sequence_id_i), .packet_id_i (packet_id_i),
    .message_handle_i (message_handle_i), .update_status_i (update_status_i),
    .clear_table_i (clear_table_i), .strobe_o (strobe), .kind_o (kind_o),
    .handle_o (handle_o), .needs_processing_o (needs_processing_o), .last_o (last_o)
  );

  // stay busy while a result that is not the last is in the output register
  assign busy = ctl_busy || (strobe && !last_o);
endmodule

// File: hw/rtl/srb_checker.sv
// port-level checks of the reorder buffer, bound to the top level
`include "session_reorder_buffer_unit_macros.svh"
module srb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [2:0] kind_o,
  input logic       last_o
);
  import srb_pkg::*;
  `SRB_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `SRB_ASSERT_IMPL(a_kind_range, clk_i, rst_ni, strobe, kind_o != 3'd7)
  `SRB_ASSERT_IMPL(a_final_kinds, clk_i, rst_ni, strobe && (kind_o == K_STORED || kind_o == K_BUSY || kind_o == K_DONE || kind_o == K_NOTHING), last_o)
  `SRB_ASSERT_IMPL(a_no_idle_strobe, clk_i, rst_ni, strobe && !last_o, busy)
endmodule

bind session_reorder_buffer_unit srb_checker u_srb_checker (
  .clk_i (clk_i), .rst_ni (rst_ni), .start (start), .busy (busy),
  .strobe (strobe), .kind_o (kind_o), .last_o (last_o)
);
